@@ sv/fnw_pkg.sv @@
// fnw_pkg: shared types, constants and zone tables for the synthesizer word calculator
// used by fnw_alu and tuner_fracn_synth_words; no dependencies
`timescale 1ns / 1ps

package fnw_pkg;

  localparam int unsigned ZoneRows = 9;
  localparam logic [2:0] BandKeep = 3'd7;
  localparam logic [26:0] XtalX4Hz = 27'd88000000;
  localparam logic [26:0] UpconvHz = 27'd110000000;
  localparam logic [63:0] ScaleAdd = 64'd4094;
  localparam logic [63:0] ScaleDiv = 64'd4095;

  typedef enum logic [0:0] {
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV_N,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_RED_T,
    ST_RED_F,
    ST_SCALE_A,
    ST_SCALE_T,
    ST_SCALE_F,
    ST_MUL_P,
    ST_MUL_R1,
    ST_DIV_R1,
    ST_MUL_R2,
    ST_DIV_R2,
    ST_MUL_AFC,
    ST_DIV_AFC,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic [3:0] idx;
    logic [2:0] shift;   // log2 of the lo divider
    logic       upconv;
    logic [2:0] band;
  } zone_t;

  typedef struct packed {
    logic       start;
    alu_op_e    op;
  } alu_ctl_t;

  function automatic logic [31:0] zone_edge_hz(input logic sel, input logic [3:0] row);
    logic [31:0] mhz;
    case (row)
      4'd1: mhz = 32'd12;
      4'd2: mhz = 32'd30;
      4'd3: mhz = 32'd50;
      4'd4: mhz = sel ? 32'd120 : 32'd108;
      4'd5: mhz = 32'd250;
      4'd6: mhz = 32'd259;
      4'd7: mhz = sel ? 32'd404 : 32'd330;
      4'd8: mhz = sel ? 32'd1000 : 32'd960;
      default: mhz = 32'd0;
    endcase
    return mhz * 32'd1000000;
  endfunction

  function automatic zone_t zone_lookup(input logic sel, input logic [31:0] f);
    zone_t z;
    logic [3:0] row;
    row = 4'd0;
    for (int i = 1; i < ZoneRows; i++) begin
      if (f >= zone_edge_hz(sel, 4'(i))) row = 4'(i);
    end
    z.idx = row;
    case (row)
      4'd0, 4'd1, 4'd2: begin z.shift = 3'd4; z.upconv = 1'b1; z.band = 3'd1; end
      4'd3: begin z.shift = 3'd5; z.upconv = 1'b0; z.band = 3'd2; end
      4'd4, 4'd5: begin z.shift = 3'd4; z.upconv = 1'b0; z.band = 3'd3; end
      4'd6: begin z.shift = 3'd3; z.upconv = 1'b0; z.band = BandKeep; end
      4'd7: begin z.shift = 3'd2; z.upconv = 1'b0; z.band = 3'd4; end
      default: begin z.shift = 3'd1; z.upconv = 1'b0; z.band = 3'd5; end
    endcase
    return z;
  endfunction

endpackage

@@ sv/fnw_alu.sv @@
// fnw_alu: shared 64-bit multiply / divide unit, one bit per cycle on one adder
// depends on fnw_pkg
`timescale 1ns / 1ps

module fnw_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fnw_pkg::alu_ctl_t ctl_i,
  input  logic [63:0]       a_i,    // dividend or multiplier
  input  logic [63:0]       b_i,    // divisor or multiplicand
  output logic              done_o,
  output logic [63:0]       res_o,  // quotient or product mod 2^64
  output logic [63:0]       rem_o
);
  import fnw_pkg::*;

  logic [63:0] a_q, a_d, b_q, r_q, r_d;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  alu_op_e     op_q;
  logic [64:0] trial;
  logic [65:0] add_a, add_b, sum;
  logic        cin;

  assign trial = {r_q, a_q[63]};

  always_comb begin
    if (op_q == OP_DIV) begin
      add_a = {1'b0, trial};
      add_b = ~{2'b00, b_q};
      cin   = 1'b1;
    end else begin
      add_a = {2'b00, r_q[62:0], 1'b0};
      add_b = a_q[63] ? {2'b00, b_q} : 66'd0;
      cin   = 1'b0;
    end
    sum = add_a + add_b + {65'd0, cin};
    if (op_q == OP_DIV) begin
      r_d = sum[65] ? trial[63:0] : sum[63:0];
      a_d = {a_q[62:0], ~sum[65]};
    end else begin
      r_d = sum[63:0];
      a_d = {a_q[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start && !run_q) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        op_q  <= ctl_i.op;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start && !run_q) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (run_q) begin
      a_q <= a_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_DIV) ? a_q : r_q;
  assign rem_o  = r_q;

endmodule

@@ sv/tuner_fracn_synth_words.sv @@
// tuner_fracn_synth_words: top level, zone lookup, sequencer and result register
// depends on fnw_pkg and fnw_alu
//
//  channel   | dir | fields (low bit first)
//  s_axis    | in  | tdata[31:0] tune_hz
//  m_axis    | out | tdata: zone_index, divider_lo, upconvert_on, band_code,
//            |     |        int_divider, modulus_word, fraction_word, afc_word
//  cfg       | in  | 0 crystal_ppm_trim, 1 table_select
//
// each request runs 13 multiply/divide passes on the shared unit, plus one divide pass per gcd step
// s_axis_tready is high only while the sequencer is idle
// the result register frees the sequencer; a stalled result holds the next one
// reset: trim -50, table 1, band AM2
`timescale 1ns / 1ps

module tuner_fracn_synth_words (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // tune_hz
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // zone_index[3:0] divider_lo[9:4] upconvert_on[10] band_code[13:11]
  // int_divider[19:14] modulus_word[31:20] fraction_word[43:32] afc_word[55:44]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [17:0] cfg_wdata_i
);
  import fnw_pkg::*;

  seq_state_e state_q, state_d;
  logic signed [17:0] trim_q;
  logic        tsel_q, issued_q;
  logic [2:0]  band_q;
  zone_t       zone, zone_q;
  logic [26:0] x4_q;
  logic [32:0] tgt_q;
  logic [63:0] n_q, th_q, fr_q, ga_q, gb_q, aa_q, p_q, rf_q;
  logic [63:0] x4w, fvco, den, alu_a, alu_b, alu_res, alu_rem;
  logic [27:0] x4s, offs;
  logic        alu_done, arith, out_free;
  alu_op_e     alu_op;
  alu_ctl_t    alu_ctl;
  logic        m_valid_q;
  logic [55:0] m_data_q;

  assign zone = zone_lookup(tsel_q, s_axis_tdata);
  assign x4s  = {1'b0, XtalX4Hz} + {{8{trim_q[17]}}, trim_q, 2'b00};
  assign offs = {1'b0, UpconvHz} + {{8{trim_q[17]}}, trim_q, 2'b00}
              + {{10{trim_q[17]}}, trim_q};
  assign x4w  = {37'd0, x4_q};
  assign fvco = {31'd0, tgt_q} << zone_q.shift;
  assign den  = (th_q << 12) << zone_q.shift;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // operand selection for the shared unit
  always_comb begin
    arith  = 1'b1;
    alu_op = OP_DIV;
    alu_a  = fvco;
    alu_b  = x4w;
    case (state_q)
      ST_DIV_N:   begin alu_a = fvco; alu_b = x4w; end
      ST_GCD_DIV: begin alu_a = gb_q; alu_b = ga_q; end
      ST_RED_T:   begin alu_a = th_q; alu_b = gb_q; end
      ST_RED_F:   begin alu_a = fr_q; alu_b = gb_q; end
      ST_SCALE_A: begin alu_a = th_q + ScaleAdd; alu_b = ScaleDiv; end
      ST_SCALE_T: begin alu_a = th_q + (aa_q >> 1); alu_b = aa_q; end
      ST_SCALE_F: begin alu_a = fr_q + (aa_q >> 1); alu_b = aa_q; end
      ST_MUL_P:   begin alu_op = OP_MUL; alu_a = n_q; alu_b = th_q; end
      ST_MUL_R1, ST_MUL_R2: begin
        alu_op = OP_MUL;
        alu_a  = (p_q + fr_q) << 12;
        alu_b  = x4w;
      end
      ST_DIV_R1, ST_DIV_R2: begin alu_a = rf_q; alu_b = den; end
      ST_MUL_AFC: begin
        alu_op = OP_MUL;
        alu_a  = {31'd0, tgt_q} - rf_q;
        alu_b  = th_q;
      end
      ST_DIV_AFC: begin alu_a = (rf_q << 12) << zone_q.shift; alu_b = x4w; end
      default: arith = 1'b0;
    endcase
    alu_ctl.start = arith && !issued_q;
    alu_ctl.op    = alu_op;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (s_axis_tvalid) state_d = ST_DIV_N;
      ST_DIV_N:   if (alu_done) state_d = ST_GCD_CHK;
      ST_GCD_CHK: state_d = (ga_q == 64'd0) ? ST_RED_T : ST_GCD_DIV;
      ST_GCD_DIV: if (alu_done) state_d = ST_GCD_CHK;
      ST_RED_T:   if (alu_done) state_d = ST_RED_F;
      ST_RED_F:   if (alu_done) state_d = ST_SCALE_A;
      ST_SCALE_A: if (alu_done) state_d = ST_SCALE_T;
      ST_SCALE_T: if (alu_done) state_d = ST_SCALE_F;
      ST_SCALE_F: if (alu_done) state_d = ST_MUL_P;
      ST_MUL_P:   if (alu_done) state_d = ST_MUL_R1;
      ST_MUL_R1:  if (alu_done) state_d = ST_DIV_R1;
      ST_DIV_R1:  if (alu_done) state_d = ST_MUL_R2;
      ST_MUL_R2:  if (alu_done) state_d = ST_DIV_R2;
      ST_DIV_R2:  if (alu_done) state_d = ST_MUL_AFC;
      ST_MUL_AFC: if (alu_done) state_d = ST_DIV_AFC;
      ST_DIV_AFC: if (alu_done) state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  fnw_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res),
    .rem_o  (alu_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issued_q  <= 1'b0;
      trim_q    <= -18'sd50;
      tsel_q    <= 1'b1;
      band_q    <= 3'd1;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (alu_done) issued_q <= 1'b0;
      else if (alu_ctl.start) issued_q <= 1'b1;
      if (cfg_we_i) begin
        if (cfg_addr_i) tsel_q <= cfg_wdata_i[0];
        else trim_q <= cfg_wdata_i;
      end
      if (state_q == ST_IDLE && s_axis_tvalid && zone.band != BandKeep) band_q <= zone.band;
      if (state_q == ST_OUT && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      zone_q <= zone;
      x4_q   <= x4s[26:0];
      tgt_q  <= {1'b0, s_axis_tdata} + (zone.upconv ? {5'd0, offs} : 33'd0);
    end
    if (alu_done) begin
      case (state_q)
        ST_DIV_N: begin
          n_q  <= alu_res;
          fr_q <= alu_rem >> zone_q.shift;
          th_q <= x4w >> zone_q.shift;
          ga_q <= x4w >> zone_q.shift;
          gb_q <= alu_rem >> zone_q.shift;
        end
        ST_GCD_DIV: begin ga_q <= alu_rem; gb_q <= ga_q; end
        ST_RED_T, ST_SCALE_T: th_q <= alu_res;
        ST_RED_F, ST_SCALE_F: fr_q <= alu_res;
        ST_SCALE_A: aa_q <= alu_res;
        ST_MUL_P:   p_q  <= alu_res;
        ST_DIV_R1: begin
          rf_q <= alu_res;
          // overshoot: lower the fraction by one
          if ({31'd0, tgt_q} < alu_res) fr_q <= fr_q - 64'd1;
        end
        ST_MUL_R1, ST_MUL_R2, ST_DIV_R2, ST_MUL_AFC: rf_q <= alu_res;
        ST_DIV_AFC: rf_q <= alu_res;
        default: ;
      endcase
    end
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= {rf_q[11:0], fr_q[11:0], th_q[11:0], n_q[5:0], band_q,
                   zone_q.upconv, 6'(6'd1 << zone_q.shift), zone_q.idx};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
